@@ sv/assert_macros.svh @@
// Assertion macros used by the datapath module of the hash table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define CHK_ALWAYS(lbl, clk, rst_n, cond)
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/mkht_pkg.sv @@
// Package with constants, codes and interface types of the hash table unit.
package mkht_pkg;

    localparam int MAX_KEY_WORDS = 4;
    localparam int ENTRIES       = 256;
    localparam int BUCKETS       = 64;

    localparam logic CFG_KEY_WORDS = 1'b0;

    localparam logic [2:0] STAT_ADDED     = 3'd0;
    localparam logic [2:0] STAT_UPDATED   = 3'd1;
    localparam logic [2:0] STAT_UNCHANGED = 3'd2;
    localparam logic [2:0] STAT_FOUND     = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_H1,
        S_H2,
        S_H3,
        S_HRD,
        S_HLD,
        S_CHK,
        S_CMP,
        S_HIT,
        S_MISS,
        S_INS,
        S_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic       capture;
        logic       hash1;
        logic       hash2;
        logic       hash3;
        logic       head_rd;
        logic       head_load;
        logic       key_rd;
        logic       follow_next;
        logic       idx_inc;
        logic       idx_clr;
        logic       depth_wr;
        logic       ins_key_wr;
        logic       ins_fin;
        logic       emit;
        logic [2:0] emit_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic key_done;
        logic head_empty;
        logic word_match;
        logic last_word;
        logic depth_diff;
        logic pool_full;
        logic lookup;
        logic ins_last;
    } dp_stat_t;

endpackage

@@ sv/mkht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mkht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mkht_ctrl.sv @@
// Controller state machine of the hash table unit.
module mkht_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mkht_pkg::dp_stat_t  st,
    output mkht_pkg::ctrl_cmd_t c,
    output logic                busy
);

    mkht_pkg::ctrl_state_t state_reg;
    mkht_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mkht_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mkht_pkg::S_IDLE: if (start) state_next = mkht_pkg::S_H1;
            mkht_pkg::S_H1:   state_next = mkht_pkg::S_H2;
            mkht_pkg::S_H2:   state_next = mkht_pkg::S_H3;
            mkht_pkg::S_H3:
                state_next = st.key_done ? mkht_pkg::S_HRD : mkht_pkg::S_IDLE;
            mkht_pkg::S_HRD:  state_next = mkht_pkg::S_HLD;
            mkht_pkg::S_HLD:  state_next = mkht_pkg::S_CHK;
            mkht_pkg::S_CHK:
                state_next = st.head_empty ? mkht_pkg::S_MISS : mkht_pkg::S_CMP;
            mkht_pkg::S_CMP:
            begin
                if (st.word_match && st.last_word)
                begin
                    state_next = mkht_pkg::S_HIT;
                end
                else
                begin
                    state_next = mkht_pkg::S_CHK;
                end
            end
            mkht_pkg::S_HIT:  state_next = mkht_pkg::S_IDLE;
            mkht_pkg::S_MISS:
            begin
                if (st.lookup || st.pool_full)
                begin
                    state_next = mkht_pkg::S_IDLE;
                end
                else
                begin
                    state_next = mkht_pkg::S_INS;
                end
            end
            mkht_pkg::S_INS:
                state_next = st.ins_last ? mkht_pkg::S_FIN : mkht_pkg::S_INS;
            mkht_pkg::S_FIN:  state_next = mkht_pkg::S_IDLE;
            default:          state_next = mkht_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        c = '0;
        unique case (state_reg)
            mkht_pkg::S_IDLE: c.capture = start;
            mkht_pkg::S_H1:   c.hash1 = 1'b1;
            mkht_pkg::S_H2:   c.hash2 = 1'b1;
            mkht_pkg::S_H3:   c.hash3 = 1'b1;
            mkht_pkg::S_HRD:  c.head_rd = 1'b1;
            mkht_pkg::S_HLD:  c.head_load = 1'b1;
            mkht_pkg::S_CHK:  c.key_rd = !st.head_empty;
            mkht_pkg::S_CMP:
            begin
                if (!st.word_match)
                begin
                    c.follow_next = 1'b1;
                end
                else if (!st.last_word)
                begin
                    c.idx_inc = 1'b1;
                end
            end
            mkht_pkg::S_HIT:
            begin
                c.emit = 1'b1;
                if (st.lookup)
                begin
                    c.emit_status = mkht_pkg::STAT_FOUND;
                end
                else if (st.depth_diff)
                begin
                    c.depth_wr    = 1'b1;
                    c.emit_status = mkht_pkg::STAT_UPDATED;
                end
                else
                begin
                    c.emit_status = mkht_pkg::STAT_UNCHANGED;
                end
            end
            mkht_pkg::S_MISS:
            begin
                if (st.lookup)
                begin
                    c.emit        = 1'b1;
                    c.emit_status = mkht_pkg::STAT_NOT_FOUND;
                end
                else if (st.pool_full)
                begin
                    c.emit        = 1'b1;
                    c.emit_status = mkht_pkg::STAT_FULL;
                end
                else
                begin
                    c.idx_clr = 1'b1;
                end
            end
            mkht_pkg::S_INS:
            begin
                c.ins_key_wr = 1'b1;
                c.idx_inc    = 1'b1;
            end
            mkht_pkg::S_FIN:
            begin
                c.ins_fin     = 1'b1;
                c.emit        = 1'b1;
                c.emit_status = mkht_pkg::STAT_ADDED;
            end
            default: c = '0;
        endcase
    end

    assign busy = (state_reg != mkht_pkg::S_IDLE);

endmodule

@@ sv/mkht_dp.sv @@
// Datapath of the hash table unit: key hashing, key buffer, tables and result registers.
`include "assert_macros.svh"
module mkht_dp #(
    parameter int MAX_KEY_WORDS = mkht_pkg::MAX_KEY_WORDS,
    parameter int ENTRIES       = mkht_pkg::ENTRIES,
    parameter int BUCKETS       = mkht_pkg::BUCKETS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mkht_pkg::ctrl_cmd_t c,
    output mkht_pkg::dp_stat_t  st,
    input  logic [2:0]          key_words,
    input  logic                cmd,
    input  logic [63:0]         key_word,
    input  logic signed [31:0]  value_in,
    input  logic signed [31:0]  depth_in,
    output logic                done,
    output logic [2:0]          status,
    output logic signed [31:0]  value_out
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int PW  = $clog2(ENTRIES + 1);
    localparam int BW  = $clog2(BUCKETS);
    localparam int CW  = $clog2(MAX_KEY_WORDS + 1);
    localparam int KIW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
    localparam int KAW = $clog2(ENTRIES * MAX_KEY_WORDS);
    localparam logic [PW-1:0] EMPTY = PW'(ENTRIES);

    logic              cmd_reg;
    logic [31:0]       val_reg;
    logic [31:0]       dep_reg;
    logic [63:0]       wd_reg;
    logic [63:0]       hk_reg;
    logic [63:0]       hk_next;
    logic [31:0]       acc_reg;
    logic [31:0]       acc_next;
    logic [CW-1:0]     wc_reg;
    logic [CW-1:0]     wc_next;
    logic [63:0]       kb_reg [MAX_KEY_WORDS];
    logic [PW-1:0]     ptr_reg;
    logic [PW-1:0]     ptr_next;
    logic [PW-1:0]     head_reg;
    logic [KIW-1:0]    idx_reg;
    logic [KIW-1:0]    idx_next;
    logic [PW-1:0]     count_reg;
    logic [BUCKETS-1:0] hv_reg;
    logic              done_reg;
    logic [2:0]        status_reg;
    logic [31:0]       vout_reg;

    logic [CW-1:0]     n;
    logic [CW-1:0]     wc_inc;
    logic [63:0]       h1;
    logic [63:0]       h2;
    logic [63:0]       h3;
    logic [BW-1:0]     bucket;
    logic [PW-1:0]     head_rdata;
    logic [PW-1:0]     next_rdata;
    logic [63:0]       key_rdata;
    logic [31:0]       value_rdata;
    logic [31:0]       depth_rdata;
    logic [63:0]       ins_word;
    logic [KAW-1:0]    key_raddr;
    logic [KAW-1:0]    key_waddr;
    logic [IW-1:0]     depth_waddr;

    always_comb
    begin
        if (key_words == 3'd0)
        begin
            n = CW'(1);
        end
        else if (32'(key_words) > 32'(MAX_KEY_WORDS))
        begin
            n = CW'(MAX_KEY_WORDS);
        end
        else
        begin
            n = CW'(key_words);
        end
    end

    assign wc_inc = wc_reg + CW'(1);
    assign bucket = acc_reg[BW-1:0];

    always_comb
    begin
        h1 = (~wd_reg) + (wd_reg << 18);
        h1 = h1 ^ (h1 >> 31);
        h2 = (hk_reg + (hk_reg << 2)) + (hk_reg << 4);
        h2 = h2 ^ (h2 >> 11);
        h3 = hk_reg + (hk_reg << 6);
        h3 = h3 ^ (h3 >> 22);
    end

    always_comb
    begin
        hk_next  = hk_reg;
        acc_next = acc_reg;
        wc_next  = wc_reg;
        ptr_next = ptr_reg;
        idx_next = idx_reg;
        if (c.hash1)
        begin
            hk_next = h1;
        end
        if (c.hash2)
        begin
            hk_next = h2;
        end
        if (c.hash3)
        begin
            acc_next = acc_reg ^ h3[31:0];
            wc_next  = wc_inc;
        end
        if (c.emit)
        begin
            acc_next = '0;
            wc_next  = '0;
        end
        if (c.head_load)
        begin
            ptr_next = hv_reg[bucket] ? head_rdata : EMPTY;
        end
        if (c.follow_next)
        begin
            ptr_next = next_rdata;
        end
        if (c.head_load || c.follow_next || c.idx_clr)
        begin
            idx_next = '0;
        end
        else if (c.idx_inc)
        begin
            idx_next = idx_reg + KIW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            wc_reg     <= '0;
            count_reg  <= '0;
            hv_reg     <= '0;
            done_reg   <= 1'b0;
            for (int i = 0; i < MAX_KEY_WORDS; i++)
            begin
                kb_reg[i] <= '0;
            end
        end
        else
        begin
            acc_reg  <= acc_next;
            wc_reg   <= wc_next;
            done_reg <= c.emit;
            if (c.capture)
            begin
                kb_reg[wc_reg[KIW-1:0]] <= key_word;
            end
            if (c.ins_fin)
            begin
                count_reg      <= count_reg + PW'(1);
                hv_reg[bucket] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hk_reg  <= hk_next;
        ptr_reg <= ptr_next;
        idx_reg <= idx_next;
        if (c.capture)
        begin
            cmd_reg <= cmd;
            val_reg <= value_in;
            dep_reg <= depth_in;
            wd_reg  <= key_word;
        end
        if (c.head_load)
        begin
            head_reg <= ptr_next;
        end
        if (c.emit)
        begin
            status_reg <= c.emit_status;
            vout_reg   <= (c.emit_status == mkht_pkg::STAT_FOUND) ? value_rdata : '0;
        end
    end

    assign key_raddr = KAW'(ptr_reg[IW-1:0]) * KAW'(MAX_KEY_WORDS) + KAW'(idx_reg);
    assign key_waddr = KAW'(count_reg[IW-1:0]) * KAW'(MAX_KEY_WORDS) + KAW'(idx_reg);
    assign ins_word  = (CW'(idx_reg) < n) ? kb_reg[idx_reg] : '0;
    assign depth_waddr = c.ins_fin ? count_reg[IW-1:0] : ptr_reg[IW-1:0];

    mkht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (c.ins_fin),
        .waddr (bucket),
        .wdata (count_reg),
        .re    (c.head_rd),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    mkht_ram #(.WIDTH(64), .DEPTH(ENTRIES * MAX_KEY_WORDS)) u_key_ram (
        .clk   (clk),
        .we    (c.ins_key_wr),
        .waddr (key_waddr),
        .wdata (ins_word),
        .re    (c.key_rd),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    mkht_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_value_ram (
        .clk   (clk),
        .we    (c.ins_fin),
        .waddr (count_reg[IW-1:0]),
        .wdata (val_reg),
        .re    (c.key_rd),
        .raddr (ptr_reg[IW-1:0]),
        .rdata (value_rdata)
    );

    mkht_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_depth_ram (
        .clk   (clk),
        .we    (c.ins_fin || c.depth_wr),
        .waddr (depth_waddr),
        .wdata (dep_reg),
        .re    (c.key_rd),
        .raddr (ptr_reg[IW-1:0]),
        .rdata (depth_rdata)
    );

    mkht_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_next_ram (
        .clk   (clk),
        .we    (c.ins_fin),
        .waddr (count_reg[IW-1:0]),
        .wdata (head_reg),
        .re    (c.key_rd),
        .raddr (ptr_reg[IW-1:0]),
        .rdata (next_rdata)
    );

    always_comb
    begin
        st.key_done   = (wc_inc >= n);
        st.head_empty = (ptr_reg == EMPTY);
        st.word_match = (key_rdata == kb_reg[idx_reg]);
        st.last_word  = (CW'(idx_reg) == n - CW'(1));
        st.depth_diff = (depth_rdata != dep_reg);
        st.pool_full  = (count_reg == EMPTY);
        st.lookup     = cmd_reg;
        st.ins_last   = (idx_reg == KIW'(MAX_KEY_WORDS - 1));
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign value_out = vout_reg;

    `CHK_ALWAYS(a_count_bound, clk, rst_n, count_reg <= EMPTY)
    `CHK_IMPLY(a_insert_room, clk, rst_n, c.ins_fin, count_reg != EMPTY)
    `CHK_IMPLY(a_value_zero, clk, rst_n, done_reg && status_reg != mkht_pkg::STAT_FOUND, vout_reg == '0)

endmodule

@@ sv/multiword_key_hash_table_unit.sv @@
// Top level of the multi-word key hash table: register port, controller and datapath.
// Each key word is accepted and then hashed in a three-step hash.
// The final word of a key then reads the bucket head, compares the key word by word along
// the chain, finds the end of the chain on a miss, decides, and on an insert writes every
// key word slot of the new entry before finishing it; done is registered from the last step.
// Reset clears the bucket valid bits, entry count and key state at once; key_words resets to 1.
module multiword_key_hash_table_unit #(
    parameter int MAX_KEY_WORDS = mkht_pkg::MAX_KEY_WORDS,
    parameter int ENTRIES       = mkht_pkg::ENTRIES,
    parameter int BUCKETS       = mkht_pkg::BUCKETS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [63:0]        key_word,
    input  logic signed [31:0] value_in,
    input  logic signed [31:0] depth_in,
    output logic               done,
    output logic [2:0]         status,
    output logic signed [31:0] value_out
);

    logic [2:0]          key_words_reg;
    logic [2:0]          key_words_next;
    logic                cfg_wr;
    mkht_pkg::ctrl_cmd_t c;
    mkht_pkg::dp_stat_t  st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == mkht_pkg::CFG_KEY_WORDS);
    assign key_words_next = cfg_wr ? pwdata[2:0] : key_words_reg;
    assign prdata = (paddr[2] == mkht_pkg::CFG_KEY_WORDS) ? {29'd0, key_words_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_words_reg <= 3'd1;
        end
        else
        begin
            key_words_reg <= key_words_next;
        end
    end

    mkht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .c     (c),
        .busy  (busy)
    );

    mkht_dp #(
        .MAX_KEY_WORDS (MAX_KEY_WORDS),
        .ENTRIES       (ENTRIES),
        .BUCKETS       (BUCKETS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .c         (c),
        .st        (st),
        .key_words (key_words_reg),
        .cmd       (cmd),
        .key_word  (key_word),
        .value_in  (value_in),
        .depth_in  (depth_in),
        .done      (done),
        .status    (status),
        .value_out (value_out)
    );

endmodule
